[sv/sqbs_pkg.sv]
// shared types and constants for the sprite quad batch setup block
package sqbs_pkg;

   localparam int SlotMax = 32;
   localparam int AtanCount = 24;
   localparam logic [30:0] HalfPiQ30 = 31'd1686629713;
   localparam logic [31:0] GainQ30 = 32'd652032874;

   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_BIND = 2'd1;
   localparam logic [1:0] KIND_DRAW = 2'd2;

   // datapath commands from the controller
   typedef struct packed {
      logic load;         // capture request and start rotation setup
      logic cordic_step;  // one cordic iteration
      logic mul_start;    // start product sequence
      logic mul_step;     // advance product sequence
      logic emit_vertex;  // load output with corner
      logic emit_bind;    // load output with bind of slot index
      logic emit_draw;    // load output with draw call
      logic set_last;
      logic [1:0] corner;
   } sqbs_cmd_type;

   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] t [0:AtanCount-1];
      t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
            32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
            32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
            32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
            32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F};
      if (i < 5'(AtanCount)) begin
         return t[i];
      end else begin
         return 32'd0;
      end
   endfunction

endpackage

[sv/sprite_quad_batch_setup_top.sv]
// top level of the sprite quad batch setup block
// sequence: the slot lookup probes the table, a miss allocates a slot, then the CORDIC
//   rotation, four products (one 32x32 multiplier) and the four vertices in turn
// throughput: one item at a time; a flush first emits a bind per used slot and then
//   the draw call
// reset: synchronous, empties the batch and sets slots used to one
module sprite_quad_batch_setup_top import sqbs_pkg::*; #(
   parameter int BATCH_QUADS = 32768,
   parameter int SLOT_COUNT = 32,
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,      // white_texture_id
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, size_x, size_y, angle, texture_id, color_rgba
   input  logic [223:0] req_tdata,
   input  logic         req_tuser,      // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vert_x, vert_y, vert_z, vert_color, tex_u, tex_v, slot_number,
   // bound_texture, index_count, zero fill
   output logic [175:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,      // kind
   output logic         rsp_tlast       // last
);

   logic [15:0] white_ff;
   sqbs_cmd_type cmd;
   logic [4:0] slot, step_cnt;
   logic [15:0] bind_tex;
   logic [17:0] count;
   logic [171:0] result;

   // white texture register
   always_ff @(posedge clock) begin
      if (reset) white_ff <= '0;
      else if (csr_we) white_ff <= csr_wdata;
   end

   sqbs_control #(
      .BATCH_QUADS(BATCH_QUADS), .SLOT_COUNT(SLOT_COUNT), .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock, .reset, .white_id(white_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_mode(req_tuser), .in_tex(req_tdata[191:176]),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .step_cnt, .cmd, .slot, .bind_tex, .count
   );

   sqbs_datapath u_dp (
      .clock, .cmd,
      .pos_x(req_tdata[31:0]), .pos_y(req_tdata[63:32]), .pos_z(req_tdata[95:64]),
      .size_x(req_tdata[127:96]), .size_y(req_tdata[159:128]),
      .angle(req_tdata[175:160]), .color(req_tdata[223:192]),
      .slot, .bind_tex, .count, .step_cnt, .result
   );

   // result word: kind in the low two bits, last on top
   assign rsp_tuser = result[1:0];
   assign rsp_tdata = {7'd0, result[170:2]};
   assign rsp_tlast = result[171];

endmodule

[sv/sqbs_datapath.sv]
// rotation, corner products and result formatting
module sqbs_datapath import sqbs_pkg::*; (
   input  logic               clock,
   input  sqbs_cmd_type       cmd,
   input  logic [31:0]        pos_x,
   input  logic [31:0]        pos_y,
   input  logic [31:0]        pos_z,
   input  logic [31:0]        size_x,
   input  logic [31:0]        size_y,
   input  logic [15:0]        angle,
   input  logic [31:0]        color,
   input  logic [4:0]         slot,
   input  logic [15:0]        bind_tex,
   input  logic [17:0]        count,
   output logic [4:0]         step_cnt,
   output logic [171:0]       result
);

   logic signed [31:0] px_ff, py_ff, sx_ff, sy_ff;
   logic [31:0] pz_ff, col_ff;
   logic flip_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic signed [33:0] x_in, y_in, z_in;
   logic [4:0] step_ff;
   logic signed [63:0] a_ff, b_ff, c_ff, d_ff;
   logic [1:0] mix_ff;
   logic [171:0] res_ff;
   logic signed [63:0] prod;
   logic signed [31:0] cs, ss;

   // angle folding and the radian scale
   logic signed [16:0] a_s, a_f;
   logic fl;
   logic [15:0] mag_a;
   logic [46:0] mag_p;
   logic signed [33:0] z0;

   always_comb begin
      a_s = 17'(signed'(angle));
      fl = (a_s > 17'sd16384) || (a_s < -17'sd16384);
      a_f = a_s;
      if (fl) begin
         a_f = a_s - 17'sd32768;
         if (a_f < -17'sd32768) a_f = a_f + 17'sd65536;
      end
      mag_a = a_f[16] ? 16'(-a_f) : a_f[15:0];
      mag_p = 47'(mag_a) * 47'(HalfPiQ30);
      z0 = a_f[16] ? -34'(mag_p[46:14]) : 34'(mag_p[46:14]);
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (z_ff >= 0) begin
         x_in = x_ff - (y_ff >>> step_ff);
         y_in = y_ff + (x_ff >>> step_ff);
         z_in = z_ff - 34'(signed'({2'b0, atan_q30(step_ff)}));
      end else begin
         x_in = x_ff + (y_ff >>> step_ff);
         y_in = y_ff - (x_ff >>> step_ff);
         z_in = z_ff + 34'(signed'({2'b0, atan_q30(step_ff)}));
      end
   end

   assign cs = flip_ff ? -x_ff[31:0] : x_ff[31:0];
   assign ss = flip_ff ? -y_ff[31:0] : y_ff[31:0];

   always_comb begin
      case (mix_ff)
         2'd0: prod = cs * sx_ff;
         2'd1: prod = ss * sy_ff;
         2'd2: prod = ss * sx_ff;
         default: prod = cs * sy_ff;
      endcase
   end

   // corner offsets and saturation
   logic signed [65:0] dx, dy, ex, ey;
   logic signed [34:0] vx, vy;
   logic [31:0] vx_s, vy_s;
   logic qx, qy;
   always_comb begin
      qx = (cmd.corner == 2'd1) || (cmd.corner == 2'd2);
      qy = cmd.corner[1];
      dx = (qx ? 66'(a_ff) : -66'(a_ff)) - (qy ? 66'(b_ff) : -66'(b_ff));
      dy = (qx ? 66'(c_ff) : -66'(c_ff)) + (qy ? 66'(d_ff) : -66'(d_ff));
      ex = (dx + 66'sd1073741824) >>> 31;
      ey = (dy + 66'sd1073741824) >>> 31;
      vx = 35'(px_ff) + ex[34:0];
      vy = 35'(py_ff) + ey[34:0];
      vx_s = (vx > 35'sd2147483647) ? 32'h7FFFFFFF :
             (vx < -35'sd2147483648) ? 32'h80000000 : vx[31:0];
      vy_s = (vy > 35'sd2147483647) ? 32'h7FFFFFFF :
             (vy < -35'sd2147483648) ? 32'h80000000 : vy[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff <= pos_x;  py_ff <= pos_y;  pz_ff <= pos_z;
         sx_ff <= size_x; sy_ff <= size_y; col_ff <= color;
         flip_ff <= fl;
         x_ff <= 34'(GainQ30);
         y_ff <= '0;
         z_ff <= z0;
         step_ff <= '0;
      end else if (cmd.cordic_step) begin
         x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
         step_ff <= step_ff + 5'd1;
      end
      if (cmd.mul_start) begin
         mix_ff <= 2'd0;
      end else if (cmd.mul_step) begin
         case (mix_ff)
            2'd0: a_ff <= prod;
            2'd1: b_ff <= prod;
            2'd2: c_ff <= prod;
            default: d_ff <= prod;
         endcase
         mix_ff <= mix_ff + 2'd1;
      end
      // fields low to high: kind x y z color u v slot bound count last
      if (cmd.emit_vertex) begin
         res_ff <= {cmd.set_last, 18'd0, 16'd0, slot, qy, qx, col_ff, pz_ff,
                    vy_s, vx_s, KIND_VERTEX};
      end else if (cmd.emit_bind) begin
         res_ff <= {cmd.set_last, 18'd0, bind_tex, slot, 2'b0, 128'd0, KIND_BIND};
      end else if (cmd.emit_draw) begin
         res_ff <= {cmd.set_last, count, 16'd0, 5'd0, 2'b0, 128'd0, KIND_DRAW};
      end
   end

   assign step_cnt = step_ff;
   assign result = res_ff;

endmodule

[sv/sqbs_control.sv]
// sequencer: slot lookup, flush, rotation and vertex emission
module sqbs_control import sqbs_pkg::*; #(
   parameter int BATCH_QUADS = 32768,
   parameter int SLOT_COUNT = 32,
   parameter int CORDIC_STEPS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [15:0]   white_id,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic          in_mode,
   input  logic [15:0]   in_tex,
   output logic          out_valid,
   input  logic          out_ready,
   input  logic [4:0]    step_cnt,
   output sqbs_cmd_type  cmd,
   output logic [4:0]    slot,
   output logic [15:0]   bind_tex,
   output logic [17:0]   count
);

   localparam logic [18:0] Limit = 19'(6 * BATCH_QUADS);
   localparam logic [5:0] SlotCap = 6'(SLOT_COUNT);
   localparam logic [4:0] Steps = 5'(CORDIC_STEPS);

   typedef enum logic [3:0] {
      IDLE, SEARCH, FLUSH_BIND, FLUSH_DRAW, ALLOC, ROTATE, MULT, VERTEX, WAIT_OUT
   } state_type;

   state_type state_ff;
   logic [15:0] table_mem [0:SlotMax-1];
   logic [5:0] used_ff;
   logic [18:0] idx_ff;
   logic [5:0] scan_ff;
   logic [4:0] slot_ff;
   logic mode_ff, vf_ff;
   logic [15:0] tex_ff;
   logic [1:0] corner_ff;
   logic [2:0] mul_ff;
   logic valid_ff;
   logic [15:0] rd_ff;
   logic [15:0] entry;

   // one entry read per cycle, registered; slot zero always the white handle
   always_ff @(posedge clock) begin
      rd_ff <= table_mem[scan_ff[4:0]];
      if (state_ff == ALLOC) table_mem[used_ff[4:0]] <= tex_ff;
   end

   assign entry = (scan_ff == 6'd0) ? white_id : rd_ff;
   // rd_ff is registered and holds table_mem[scan] in the cycle after; each probe waits for it

   logic probe_ff;

   always_comb begin
      cmd = '0;
      cmd.corner = corner_ff;
      cmd.load = (state_ff == IDLE) && in_valid && !in_mode;
      cmd.cordic_step = (state_ff == ROTATE) && (step_cnt < Steps) &&
                        (step_cnt < 5'(AtanCount));
      cmd.mul_start = (state_ff == ROTATE);
      cmd.mul_step = (state_ff == MULT);
      cmd.emit_vertex = (state_ff == VERTEX) && (!valid_ff || out_ready);
      cmd.emit_bind = (state_ff == FLUSH_BIND) && probe_ff && (!valid_ff || out_ready);
      cmd.emit_draw = (state_ff == FLUSH_DRAW) && (!valid_ff || out_ready);
      cmd.set_last = (state_ff == VERTEX) ? (corner_ff == 2'd3) :
                     (state_ff == FLUSH_DRAW) ? mode_ff : 1'b0;
   end

   assign in_ready = (state_ff == IDLE);
   assign out_valid = valid_ff;
   assign slot = (state_ff == FLUSH_BIND) ? scan_ff[4:0] : slot_ff;
   assign bind_tex = entry;
   assign count = idx_ff[17:0];

   logic emit;
   assign emit = cmd.emit_vertex || cmd.emit_bind || cmd.emit_draw;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         used_ff <= 6'd1;
         idx_ff <= '0;
         valid_ff <= 1'b0;
         scan_ff <= '0;
         probe_ff <= 1'b0;
         corner_ff <= '0;
         mul_ff <= '0;
         slot_ff <= '0;
         mode_ff <= 1'b0;
         tex_ff <= '0;
         vf_ff <= 1'b0;
      end else begin
         if (emit) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (in_valid) begin
                  mode_ff <= in_mode;
                  tex_ff <= in_tex;
                  scan_ff <= '0;
                  probe_ff <= 1'b0;
                  if (in_mode || idx_ff >= Limit) begin
                     if (idx_ff != 0) state_ff <= FLUSH_BIND;
                     else begin
                        used_ff <= 6'd1;
                        state_ff <= in_mode ? IDLE : SEARCH;
                     end
                  end else begin
                     state_ff <= SEARCH;
                  end
               end
            end
            FLUSH_BIND: begin
               if (!probe_ff) probe_ff <= 1'b1;
               else if (cmd.emit_bind) begin
                  probe_ff <= 1'b0;
                  if (scan_ff + 6'd1 >= used_ff) state_ff <= FLUSH_DRAW;
                  else scan_ff <= scan_ff + 6'd1;
               end
            end
            FLUSH_DRAW: begin
               if (cmd.emit_draw) begin
                  idx_ff <= '0;
                  used_ff <= 6'd1;
                  scan_ff <= '0;
                  probe_ff <= 1'b0;
                  if (mode_ff) state_ff <= IDLE;
                  else if (vf_ff) state_ff <= ALLOC;
                  else state_ff <= SEARCH;
               end
            end
            SEARCH: begin
               vf_ff <= 1'b0;
               if (!probe_ff) probe_ff <= 1'b1;
               else begin
                  probe_ff <= 1'b0;
                  if (entry == tex_ff) begin
                     slot_ff <= scan_ff[4:0];
                     state_ff <= ROTATE;
                  end else if (scan_ff + 6'd1 < used_ff && scan_ff < 6'd31) begin
                     scan_ff <= scan_ff + 6'd1;
                  end else if (used_ff >= SlotCap || used_ff >= 6'd32) begin
                     scan_ff <= '0;
                     vf_ff <= 1'b1;
                     if (idx_ff != 0) state_ff <= FLUSH_BIND;
                     else begin
                        used_ff <= 6'd1;
                        state_ff <= ALLOC;
                     end
                  end else begin
                     state_ff <= ALLOC;
                  end
               end
            end
            ALLOC: begin
               vf_ff <= 1'b0;
               slot_ff <= used_ff[4:0];
               used_ff <= used_ff + 6'd1;
               state_ff <= ROTATE;
            end
            ROTATE: begin
               mul_ff <= '0;
               if (!cmd.cordic_step) state_ff <= MULT;
            end
            MULT: begin
               mul_ff <= mul_ff + 3'd1;
               if (mul_ff == 3'd3) begin
                  corner_ff <= '0;
                  state_ff <= VERTEX;
               end
            end
            VERTEX: begin
               if (cmd.emit_vertex) begin
                  corner_ff <= corner_ff + 2'd1;
                  if (corner_ff == 2'd3) begin
                     idx_ff <= idx_ff + 19'd6;
                     state_ff <= IDLE;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

[dv/tb_sprite_quad_batch_setup_top.sv]
// self-checking testbench for the sprite quad batch setup block
module tb_sprite_quad_batch_setup_top import sqbs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BatchQuads = 32768;
   localparam int SlotCount = 32;
   localparam int CordicSteps = 16;
   localparam longint HalfPi = 64'd1686629713;
   localparam longint Gain = 64'd652032874;
   localparam int StallLimit = 20000;  // cycles without any beat
   localparam int SettleCycles = 300;  // settling time for a busy empty flush or sprite to finish

   localparam longint AtanTab [0:23] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

   localparam logic MODE_DRAW = 1'b0;
   localparam logic MODE_END_SCENE = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] vz;
      logic [31:0] color;
      logic        u;
      logic        v;
      logic [4:0]  slot;
      logic [15:0] bound;
      logic [17:0] count;
      logic        last;
   } beat_type;

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [15:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [223:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [175:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   sprite_quad_batch_setup_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // predictor state, mirrors the batch held inside the block
   logic [15:0] white_id;
   logic [15:0] slot_tab [0:31];
   int          used_slots;
   int          batch_count;
   beat_type    pending_q [$];

   int  errors;
   bit  send_gaps;     // sender bursts and gaps when set
   bit  sink_stalls;   // receiver stall pattern when set
   int  burst_left;
   int  idle_cycles;

   // clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   function automatic logic [15:0] slot_value(int i);
      return (i == 0) ? white_id : slot_tab[i];
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   // binds for every used slot then the draw call; an empty batch emits nothing
   task automatic predict_flush();
      beat_type b;
      if (batch_count != 0) begin
         for (int i = 0; i < used_slots; i++) begin
            b = '0;
            b.kind = KIND_BIND;
            b.slot = 5'(i);
            b.bound = slot_value(i);
            pending_q.push_back(b);
         end
         b = '0;
         b.kind = KIND_DRAW;
         b.count = 18'(batch_count);
         pending_q.push_back(b);
      end
      batch_count = 0;
      used_slots = 1;
   endtask

   // fixed-step cordic, half turn folded away first
   task automatic sin_cos(input logic [15:0] ang, output longint c, output longint s);
      longint a, x, y, z, mag, nx;
      bit     flip;
      a = longint'($signed(ang));
      flip = 1'b0;
      if (a > 16384 || a < -16384) begin
         flip = 1'b1;
         a -= 32768;
         if (a < -32768) a += 65536;
      end
      mag = ((a < 0) ? -a : a) * HalfPi;
      mag = mag >>> 14;
      z = (a < 0) ? -mag : mag;
      x = Gain;
      y = 0;
      for (int i = 0; i < CordicSteps; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= AtanTab[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += AtanTab[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   task automatic predict_item(input logic mode, input logic [223:0] d);
      logic [15:0] tex;
      int          slot, first;
      bit          hit;
      longint      px, py, sx, sy, c, s, cx, sy_s, sx_s, cy, dx, dy;
      beat_type    b;
      int          qx, qy;
      first = pending_q.size();
      if (mode == MODE_END_SCENE) begin
         predict_flush();
      end else begin
         tex = d[191:176];
         if (batch_count >= 6 * BatchQuads) predict_flush();
         hit = 1'b0;
         slot = 0;
         for (int i = 0; i < used_slots; i++) begin
            if (!hit && slot_value(i) == tex) begin
               hit = 1'b1;
               slot = i;
            end
         end
         if (!hit) begin
            if (used_slots >= SlotCount) predict_flush();
            slot = used_slots;
            slot_tab[slot] = tex;
            used_slots++;
         end
         px = longint'($signed(d[31:0]));
         py = longint'($signed(d[63:32]));
         sx = longint'($signed(d[127:96]));
         sy = longint'($signed(d[159:128]));
         sin_cos(d[175:160], c, s);
         cx = c * sx;
         sy_s = s * sy;
         sx_s = s * sx;
         cy = c * sy;
         // corners in order (-,-) (+,-) (+,+) (-,+)
         for (int k = 0; k < 4; k++) begin
            qx = (k == 1 || k == 2) ? 1 : -1;
            qy = (k >= 2) ? 1 : -1;
            dx = ((qx > 0) ? cx : -cx) - ((qy > 0) ? sy_s : -sy_s);
            dy = ((qx > 0) ? sx_s : -sx_s) + ((qy > 0) ? cy : -cy);
            dx = (dx + (64'sd1 <<< 30)) >>> 31;
            dy = (dy + (64'sd1 <<< 30)) >>> 31;
            b = '0;
            b.kind = KIND_VERTEX;
            b.vx = clamp32(px + dx);
            b.vy = clamp32(py + dy);
            b.vz = d[95:64];
            b.color = d[223:192];
            b.u = (qx > 0);
            b.v = (qy > 0);
            b.slot = 5'(slot);
            pending_q.push_back(b);
         end
         batch_count += 6;
      end
      if (pending_q.size() > first) pending_q[$].last = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            $error("unexpected result beat kind=%0d", rsp_tuser);
            errors++;
         end else begin
            want = pending_q.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[31:0] !== want.vx) begin
               $error("vert_x: expected %h, got %h", want.vx, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== want.vy) begin
               $error("vert_y: expected %h, got %h", want.vy, rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tdata[95:64] !== want.vz) begin
               $error("vert_z: expected %h, got %h", want.vz, rsp_tdata[95:64]);
               errors++;
            end
            if (rsp_tdata[127:96] !== want.color) begin
               $error("vert_color: expected %h, got %h", want.color, rsp_tdata[127:96]);
               errors++;
            end
            if (rsp_tdata[128] !== want.u) begin
               $error("tex_u: expected %0d, got %0d", want.u, rsp_tdata[128]);
               errors++;
            end
            if (rsp_tdata[129] !== want.v) begin
               $error("tex_v: expected %0d, got %0d", want.v, rsp_tdata[129]);
               errors++;
            end
            if (rsp_tdata[134:130] !== want.slot) begin
               $error("slot_number: expected %0d, got %0d", want.slot, rsp_tdata[134:130]);
               errors++;
            end
            if (rsp_tdata[150:135] !== want.bound) begin
               $error("bound_texture: expected %h, got %h", want.bound, rsp_tdata[150:135]);
               errors++;
            end
            if (rsp_tdata[168:151] !== want.count) begin
               $error("index_count: expected %0d, got %0d", want.count, rsp_tdata[168:151]);
               errors++;
            end
            if (rsp_tdata[175:169] !== '0) begin
               $error("zero fill: expected 0, got %h", rsp_tdata[175:169]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern: mostly ready, short random stalls and rare long ones
   int stall_left;
   always @(posedge clock) begin
      if (!sink_stalls) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 9) < 3) begin
         stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("sprite_quad_batch_setup_top verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------

   task automatic send_item(input logic mode, input logic [223:0] d);
      int gap;
      if (send_gaps && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         burst_left = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      predict_item(mode, d);
   endtask

   task automatic end_stream();
      req_tvalid <= 1'b0;
      req_tuser <= 1'b0;
   endtask

   function automatic logic [223:0] sprite(logic [31:0] px, logic [31:0] py,
                                          logic [31:0] pz, logic [31:0] sx,
                                          logic [31:0] sy, logic [15:0] ang,
                                          logic [15:0] tex, logic [31:0] col);
      return {col, tex, ang, sy, sx, pz, py, px};
   endfunction

   // wait out every expected result, then let a possibly busy block settle
   task automatic drain();
      end_stream();
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_white(input logic [15:0] id);
      csr_we <= 1'b1;
      csr_wdata <= id;
      @(posedge clock);
      csr_we <= 1'b0;
      white_id = id;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      endcase
   endfunction

   function automatic logic [223:0] rand_sprite(logic [15:0] tex);
      return sprite(rand_coord(), rand_coord(), $urandom(), rand_coord(), rand_coord(),
                    16'($urandom()), tex, $urandom());
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // field extremes, every angle quadrant edge, saturation, empty end of scene
   task automatic test_directed();
      logic [15:0] angs [0:7] = '{16'h0000, 16'h4000, 16'h4001, 16'h8000,
                                 16'hC000, 16'hBFFF, 16'hFFFF, 16'h2000};
      write_white(16'h0000);
      send_item(MODE_END_SCENE, '0);  // empty batch: no result
      foreach (angs[i])
         send_item(MODE_DRAW, sprite(32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678,
                                     32'h0004_0000, 32'hFFFE_0000, angs[i],
                                     16'(i), 32'hFF00_80C1));
      // saturation at both rails, mirrored sizes
      send_item(MODE_DRAW, sprite(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000,
                                  16'hFFFF, 32'hFFFF_FFFF));
      send_item(MODE_DRAW, sprite(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 16'h6000,
                                  16'h0000, 32'h0000_0000));
      send_item(MODE_DRAW, sprite(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'hFFFF,
                                  16'hFFFF, 32'h0));
      send_item(MODE_END_SCENE, '0);
      send_item(MODE_END_SCENE, '0);
      drain();
   endtask

   // 31 distinct misses fill the slot table, the next miss forces a flush
   task automatic test_slot_overflow();
      write_white(16'hFFFF);
      for (int i = 0; i < SlotCount + 2; i++)
         send_item(MODE_DRAW, rand_sprite(16'(16'h1000 + i)));
      send_item(MODE_DRAW, rand_sprite(16'hFFFF));
      send_item(MODE_END_SCENE, '0);
      drain();
   endtask

   // random scenes over several white texture settings
   task automatic test_random_scenes();
      logic [15:0] whites [0:3];
      logic [15:0] tex;
      int          per_phase;
      whites = '{16'h0000, 16'hFFFF, 16'($urandom()), 16'($urandom())};
      per_phase = 101;
      foreach (whites[p]) begin
         write_white(whites[p]);
         send_gaps = (p != 1);
         sink_stalls = (p != 1);
         for (int i = 0; i < per_phase; i++) begin
            // hold off until the block has delivered everything
            if (p == 2 && i == per_phase / 2) begin
               end_stream();
               while (pending_q.size() != 0) @(posedge clock);
            end
            if ($urandom_range(0, 24) == 0) begin
               send_item(MODE_END_SCENE, {$urandom(), $urandom(), $urandom(), $urandom(),
                                          $urandom(), $urandom(), $urandom()});
            end else begin
               case ($urandom_range(0, 9))
                  0: tex = whites[p];
                  1: tex = 16'($urandom());
                  default: tex = 16'($urandom_range(0, 39)) ^ {16{p[0]}};
               endcase
               send_item(MODE_DRAW, rand_sprite(tex));
            end
         end
         send_item(MODE_END_SCENE, '0);
         drain();
      end
      send_gaps = 1'b1;
      sink_stalls = 1'b1;
   endtask

   initial begin
      errors = 0;
      burst_left = 0;
      idle_cycles = 0;
      stall_left = 0;
      send_gaps = 1'b1;
      sink_stalls = 1'b1;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      white_id = '0;
      foreach (slot_tab[i]) slot_tab[i] = '0;
      used_slots = 1;
      batch_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_slot_overflow();
      test_random_scenes();

      if (errors == 0) begin
         $display("sprite_quad_batch_setup_top verification clean");
      end else begin
         $display("sprite_quad_batch_setup_top verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/sqbs_pkg.sv
sv/sqbs_datapath.sv
sv/sqbs_control.sv
sv/sprite_quad_batch_setup_top.sv
dv/tb_sprite_quad_batch_setup_top.sv
